// ===== sv/dtr_pkg.sv =====
// shared types and constants for the destination table router
// field widths, command codes, controller states and the result bundle
// no dependencies
package dtr_pkg;

    localparam int CMD_W   = 2;
    localparam int DEST_W  = 10;
    localparam int SLOT_W  = 3;
    localparam int PORT_W  = 6;
    localparam int COUNT_W = 4;

    // highest output port number plus one; wider port values are dropped
    localparam int NUM_PORTS = 64;

    localparam int NUM_DEST_DEFAULT  = 1024;
    localparam int MAX_GROUP_DEFAULT = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROUTE      = 2'd0,
        CMD_WRITE_SLOT = 2'd1,
        CMD_SET_SIZE   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic              no_route;
    } res_t;

endpackage

// ===== sv/dtr_entry_store.sv =====
// per-destination entry store: group size and rotate pointer in one memory
// clears every entry after reset, one a cycle; uses dtr_pkg
module dtr_entry_store #(
    parameter int NUM_DEST  = dtr_pkg::NUM_DEST_DEFAULT,
    parameter int MAX_GROUP = dtr_pkg::MAX_GROUP_DEFAULT,
    localparam int IDX_W  = $clog2(NUM_DEST),
    localparam int PTR_W  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int SIZE_W = $clog2(MAX_GROUP + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [SIZE_W-1:0] rd_size,
    output logic [PTR_W-1:0]  rd_ptr,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [SIZE_W-1:0] wr_size,
    input  logic [PTR_W-1:0]  wr_ptr,
    output logic              busy
);
    import dtr_pkg::*;

    localparam int ENTRY_W = SIZE_W + PTR_W;

    logic [ENTRY_W-1:0] mem [NUM_DEST];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    always_comb
    begin
        busy_next    = busy_reg;
        clr_idx_next = clr_idx_reg;
        if (busy_reg)
        begin
            if (clr_idx_reg == IDX_W'(NUM_DEST - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // the sweep owns the write port until it is done
    always_comb
    begin
        if (busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_idx;
            mem_wdata = {wr_size, wr_ptr};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_size = rd_data_reg[ENTRY_W-1:PTR_W];
    assign rd_ptr  = rd_data_reg[PTR_W-1:0];
    assign busy    = busy_reg;

endmodule

// ===== sv/dtr_slot_store.sv =====
// port slot store: one output port number per group slot of each destination
// addressed as destination index over slot position; uses dtr_pkg
module dtr_slot_store #(
    parameter int NUM_DEST  = dtr_pkg::NUM_DEST_DEFAULT,
    parameter int MAX_GROUP = dtr_pkg::MAX_GROUP_DEFAULT,
    localparam int IDX_W = $clog2(NUM_DEST),
    localparam int PTR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [PTR_W-1:0]          wr_slot,
    input  logic [dtr_pkg::PORT_W-1:0] wr_port,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_idx,
    input  logic [PTR_W-1:0]          rd_slot,
    output logic [dtr_pkg::PORT_W-1:0] rd_port
);
    import dtr_pkg::*;

    localparam int DEPTH = NUM_DEST * (2 ** PTR_W);

    logic [PORT_W-1:0] mem [DEPTH];
    logic [PORT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_idx, wr_slot}] <= wr_port;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{rd_idx, rd_slot}];
        end
    end

    assign rd_port = rd_data_reg;

endmodule

// ===== sv/dtr_ctrl.sv =====
// command sequencer: decodes items, runs the entry read-modify-write and
// the slot fetch, hands one result to the output stage; uses dtr_pkg
module dtr_ctrl #(
    parameter int NUM_DEST  = dtr_pkg::NUM_DEST_DEFAULT,
    parameter int MAX_GROUP = dtr_pkg::MAX_GROUP_DEFAULT,
    localparam int IDX_W  = $clog2(NUM_DEST),
    localparam int PTR_W  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int SIZE_W = $clog2(MAX_GROUP + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [dtr_pkg::CMD_W-1:0]   cmd,
    input  logic [dtr_pkg::DEST_W-1:0]  dest,
    input  logic [dtr_pkg::SLOT_W-1:0]  slot,
    input  logic [dtr_pkg::PORT_W-1:0]  port_value,
    input  logic [dtr_pkg::COUNT_W-1:0] group_count,
    input  logic                        clear_busy,
    output logic                        ent_rd_en,
    output logic [IDX_W-1:0]            ent_rd_idx,
    input  logic [SIZE_W-1:0]           ent_rd_size,
    input  logic [PTR_W-1:0]            ent_rd_ptr,
    output logic                        ent_wr_en,
    output logic [IDX_W-1:0]            ent_wr_idx,
    output logic [SIZE_W-1:0]           ent_wr_size,
    output logic [PTR_W-1:0]            ent_wr_ptr,
    output logic                        slt_wr_en,
    output logic [IDX_W-1:0]            slt_wr_idx,
    output logic [PTR_W-1:0]            slt_wr_slot,
    output logic [dtr_pkg::PORT_W-1:0]  slt_wr_port,
    output logic                        slt_rd_en,
    output logic [IDX_W-1:0]            slt_rd_idx,
    output logic [PTR_W-1:0]            slt_rd_slot,
    input  logic [dtr_pkg::PORT_W-1:0]  slt_rd_port,
    output dtr_pkg::res_t               res,
    input  logic                        res_take
);
    import dtr_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             miss_reg;
    logic             miss_next;

    logic              accept;
    cmd_t              cmd_code;
    logic              dest_ok;
    logic              slot_ok;
    logic              port_ok;
    logic [IDX_W-1:0]  dest_idx;
    logic [SIZE_W-1:0] sat_count;
    logic              empty;
    logic [SIZE_W-1:0] ptr_cur;
    logic [SIZE_W-1:0] ptr_inc;
    logic [PTR_W-1:0]  ptr_new;

    assign req_ready = (state_reg == ST_IDLE) && !clear_busy;
    assign accept    = req_valid && req_ready;
    assign cmd_code  = cmd_t'(cmd);

    assign dest_ok   = 32'(dest) < NUM_DEST;
    assign slot_ok   = 32'(slot) < MAX_GROUP;
    assign port_ok   = 32'(port_value) < NUM_PORTS;
    assign dest_idx  = IDX_W'(32'(dest));
    assign sat_count = (32'(group_count) > MAX_GROUP) ? SIZE_W'(MAX_GROUP)
                                                      : SIZE_W'(group_count);

    // pointer past the group size restarts at zero, then advance with wrap
    assign empty   = miss_reg || (ent_rd_size == '0);
    assign ptr_cur = (SIZE_W'(ent_rd_ptr) >= ent_rd_size) ? '0 : SIZE_W'(ent_rd_ptr);
    assign ptr_inc = ptr_cur + 1'b1;
    assign ptr_new = (ptr_inc >= ent_rd_size) ? '0 : ptr_inc[PTR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        miss_next  = miss_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_code == CMD_ROUTE))
                begin
                    state_next = ST_LOOKUP;
                    idx_next   = dest_idx;
                    miss_next  = !dest_ok;
                end
            end
            ST_LOOKUP:
            begin
                if (!empty)
                begin
                    state_next = ST_FETCH;
                end
                else if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        miss_reg <= miss_next;
    end

    always_comb
    begin
        ent_rd_en    = 1'b0;
        ent_rd_idx   = dest_idx;
        ent_wr_en    = 1'b0;
        ent_wr_idx   = dest_idx;
        ent_wr_size  = sat_count;
        ent_wr_ptr   = '0;
        slt_wr_en    = 1'b0;
        slt_wr_idx   = dest_idx;
        slt_wr_slot  = PTR_W'(32'(slot));
        slt_wr_port  = port_value;
        slt_rd_en    = 1'b0;
        slt_rd_idx   = idx_reg;
        slt_rd_slot  = ptr_cur[PTR_W-1:0];
        res.valid    = 1'b0;
        res.port     = '0;
        res.no_route = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_code)
                        CMD_ROUTE:
                        begin
                            ent_rd_en = 1'b1;
                        end
                        CMD_WRITE_SLOT:
                        begin
                            slt_wr_en = dest_ok && slot_ok && port_ok;
                        end
                        CMD_SET_SIZE:
                        begin
                            ent_wr_en = dest_ok;
                        end
                        default:
                        begin
                            ent_rd_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (empty)
                begin
                    res.valid = 1'b1;
                end
                else
                begin
                    // write back the advanced pointer, size unchanged
                    ent_wr_en   = 1'b1;
                    ent_wr_idx  = idx_reg;
                    ent_wr_size = ent_rd_size;
                    ent_wr_ptr  = ptr_new;
                    slt_rd_en   = 1'b1;
                end
            end
            ST_FETCH:
            begin
                res.valid    = 1'b1;
                res.port     = slt_rd_port;
                res.no_route = 1'b0;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/dest_table_round_robin_router.sv =====
// top level of the destination table router with round-robin port groups
// holds the result register; uses dtr_pkg, dtr_entry_store, dtr_slot_store,
// dtr_ctrl
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  request | req_valid / req_ready  | cmd, dest, slot, port_value, group_count
//  result  | rsp_valid / rsp_ready  | out_port, no_route
//
// a route to a loaded group runs the entry memory read-modify-write and then
// the dependent slot read: entry read, pointer write-back with slot read, handoff
// a route to an empty group reads no slot and hands off in place of the write-back;
// slot writes, group size writes and unused commands finish as they are taken
// after reset the entry memory is cleared one entry a cycle, and no item is taken
// until it is done; a full result register stalls a route in its last step until
// taken
module dest_table_round_robin_router #(
    parameter int NUM_DEST  = dtr_pkg::NUM_DEST_DEFAULT,
    parameter int MAX_GROUP = dtr_pkg::MAX_GROUP_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [dtr_pkg::CMD_W-1:0]   cmd,
    input  logic [dtr_pkg::DEST_W-1:0]  dest,
    input  logic [dtr_pkg::SLOT_W-1:0]  slot,
    input  logic [dtr_pkg::PORT_W-1:0]  port_value,
    input  logic [dtr_pkg::COUNT_W-1:0] group_count,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [dtr_pkg::PORT_W-1:0]  out_port,
    output logic                        no_route
);
    import dtr_pkg::*;

    localparam int IDX_W  = $clog2(NUM_DEST);
    localparam int PTR_W  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int SIZE_W = $clog2(MAX_GROUP + 1);

    // entry store wiring
    logic              clear_busy;
    logic              ent_rd_en;
    logic [IDX_W-1:0]  ent_rd_idx;
    logic [SIZE_W-1:0] ent_rd_size;
    logic [PTR_W-1:0]  ent_rd_ptr;
    logic              ent_wr_en;
    logic [IDX_W-1:0]  ent_wr_idx;
    logic [SIZE_W-1:0] ent_wr_size;
    logic [PTR_W-1:0]  ent_wr_ptr;

    // slot store wiring
    logic              slt_wr_en;
    logic [IDX_W-1:0]  slt_wr_idx;
    logic [PTR_W-1:0]  slt_wr_slot;
    logic [PORT_W-1:0] slt_wr_port;
    logic              slt_rd_en;
    logic [IDX_W-1:0]  slt_rd_idx;
    logic [PTR_W-1:0]  slt_rd_slot;
    logic [PORT_W-1:0] slt_rd_port;

    // result handoff
    res_t res;
    logic res_take;
    logic res_load;

    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [PORT_W-1:0] out_port_reg;
    logic              no_route_reg;

    dtr_entry_store #(
        .NUM_DEST  (NUM_DEST),
        .MAX_GROUP (MAX_GROUP)
    ) u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ent_rd_en),
        .rd_idx  (ent_rd_idx),
        .rd_size (ent_rd_size),
        .rd_ptr  (ent_rd_ptr),
        .wr_en   (ent_wr_en),
        .wr_idx  (ent_wr_idx),
        .wr_size (ent_wr_size),
        .wr_ptr  (ent_wr_ptr),
        .busy    (clear_busy)
    );

    dtr_slot_store #(
        .NUM_DEST  (NUM_DEST),
        .MAX_GROUP (MAX_GROUP)
    ) u_slot (
        .clk     (clk),
        .wr_en   (slt_wr_en),
        .wr_idx  (slt_wr_idx),
        .wr_slot (slt_wr_slot),
        .wr_port (slt_wr_port),
        .rd_en   (slt_rd_en),
        .rd_idx  (slt_rd_idx),
        .rd_slot (slt_rd_slot),
        .rd_port (slt_rd_port)
    );

    dtr_ctrl #(
        .NUM_DEST  (NUM_DEST),
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .dest        (dest),
        .slot        (slot),
        .port_value  (port_value),
        .group_count (group_count),
        .clear_busy  (clear_busy),
        .ent_rd_en   (ent_rd_en),
        .ent_rd_idx  (ent_rd_idx),
        .ent_rd_size (ent_rd_size),
        .ent_rd_ptr  (ent_rd_ptr),
        .ent_wr_en   (ent_wr_en),
        .ent_wr_idx  (ent_wr_idx),
        .ent_wr_size (ent_wr_size),
        .ent_wr_ptr  (ent_wr_ptr),
        .slt_wr_en   (slt_wr_en),
        .slt_wr_idx  (slt_wr_idx),
        .slt_wr_slot (slt_wr_slot),
        .slt_wr_port (slt_wr_port),
        .slt_rd_en   (slt_rd_en),
        .slt_rd_idx  (slt_rd_idx),
        .slt_rd_slot (slt_rd_slot),
        .slt_rd_port (slt_rd_port),
        .res         (res),
        .res_take    (res_take)
    );

    // the result register frees up in the same cycle its item is taken
    assign res_take = !rsp_valid_reg || rsp_ready;
    assign res_load = res.valid && res_take;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload holds while a result waits
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_port_reg <= res.port;
            no_route_reg <= res.no_route;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign out_port  = out_port_reg;
    assign no_route  = no_route_reg;

endmodule
